@@ design/dad_pkg.sv @@
package dad_pkg;

  localparam int unsigned MONTH_BITS  = 4;
  localparam int unsigned DAY_BITS    = 5;
  localparam int unsigned YIN_BITS    = 16;
  localparam int unsigned OFFS_BITS   = 16;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned M400_BITS   = 9;

  localparam logic [YIN_BITS-1:0] MIN_YEAR_RST = 16'd1583;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_BAD_MONTH = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD_DAY   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_BAD_YEAR  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 3'd4;

  localparam logic [MONTH_BITS-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MON_DEC = 4'd12;

  localparam int unsigned PC_BITS = 3;
  typedef logic [PC_BITS-1:0] dad_pc_t;

  // Jump conditions of a control word
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_MOD_BUSY,
    COND_BAD,
    COND_WALK_MORE,
    COND_OUT_BUSY
  } dad_cond_e;

  typedef struct packed {
    logic      ld_in;
    logic      mod_step;
    logic      check;
    logic      walk;
    logic      emit;
    dad_cond_e cond;
    dad_pc_t   target;
  } dad_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic mod_busy;
    logic bad;
    logic walk_more;
    logic out_busy;
  } dad_flags_t;

  // Leap rule on the year modulo 400: divisible by 4, not a century unless year mod 400 is 0
  function automatic logic is_leap(input logic [M400_BITS-1:0] m400);
    logic century;
    century = (m400 == 9'd100) || (m400 == 9'd200) || (m400 == 9'd300);
    return (m400[1:0] == 2'd0) && !century;
  endfunction

  function automatic logic [DAY_BITS-1:0] days_in(input logic [MONTH_BITS-1:0] month,
                                                  input logic leap);
    logic [DAY_BITS-1:0] n;
    case (month)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

@@ design/dad_in_if.sv @@
interface dad_in_if
  import dad_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [MONTH_BITS-1:0] start_month;
  logic [DAY_BITS-1:0]   start_day;
  logic [YIN_BITS-1:0]   start_year;
  logic [OFFS_BITS-1:0]  days_away;

  modport source (output valid, start_month, start_day, start_year, days_away, input ready);
  modport sink   (input valid, start_month, start_day, start_year, days_away, output ready);
endinterface

@@ design/dad_out_if.sv @@
interface dad_out_if
  import dad_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [MONTH_BITS-1:0]  new_month;
  logic [DAY_BITS-1:0]    new_day;
  logic [YIN_BITS-1:0]    new_year;
  logic [STATUS_BITS-1:0] status;

  modport source (output valid, new_month, new_day, new_year, status, input ready);
  modport sink   (input valid, new_month, new_day, new_year, status, output ready);
endinterface

@@ design/dad_useq.sv @@
module dad_useq
  import dad_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dad_flags_t flags_i,
  output dad_ctl_t   ctl_o
);

  localparam dad_pc_t STEP_IDLE  = 3'd0;
  localparam dad_pc_t STEP_MOD   = 3'd1;
  localparam dad_pc_t STEP_CHECK = 3'd2;
  localparam dad_pc_t STEP_WALK  = 3'd3;
  localparam dad_pc_t STEP_EMIT  = 3'd4;
  localparam dad_pc_t STEP_RET   = 3'd5;

  dad_pc_t pc_q, pc_d;
  logic    taken;

  // Control store
  always_comb begin
    ctl_o = '{ld_in: 1'b0, mod_step: 1'b0, check: 1'b0, walk: 1'b0, emit: 1'b0,
              cond: COND_ALWAYS, target: STEP_IDLE};
    case (pc_q)
      STEP_IDLE: begin
        ctl_o.ld_in  = 1'b1;
        ctl_o.cond   = COND_NO_IN;
        ctl_o.target = STEP_IDLE;
      end
      STEP_MOD: begin
        ctl_o.mod_step = 1'b1;
        ctl_o.cond     = COND_MOD_BUSY;
        ctl_o.target   = STEP_MOD;
      end
      STEP_CHECK: begin
        ctl_o.check  = 1'b1;
        ctl_o.cond   = COND_BAD;
        ctl_o.target = STEP_EMIT;
      end
      STEP_WALK: begin
        ctl_o.walk   = 1'b1;
        ctl_o.cond   = COND_WALK_MORE;
        ctl_o.target = STEP_WALK;
      end
      STEP_EMIT: begin
        ctl_o.emit   = 1'b1;
        ctl_o.cond   = COND_OUT_BUSY;
        ctl_o.target = STEP_EMIT;
      end
      STEP_RET: begin
        ctl_o.cond   = COND_ALWAYS;
        ctl_o.target = STEP_IDLE;
      end
      default: begin
        ctl_o.cond   = COND_ALWAYS;
        ctl_o.target = STEP_IDLE;
      end
    endcase
  end

  always_comb begin
    case (ctl_o.cond)
      COND_NEVER:     taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_NO_IN:     taken = !flags_i.in_valid;
      COND_MOD_BUSY:  taken = flags_i.mod_busy;
      COND_BAD:       taken = flags_i.bad;
      COND_WALK_MORE: taken = flags_i.walk_more;
      COND_OUT_BUSY:  taken = flags_i.out_busy;
      default:        taken = 1'b1;
    endcase
    pc_d = taken ? ctl_o.target : pc_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ design/dad_datapath.sv @@
module dad_datapath
  import dad_pkg::*;
#(
  parameter int unsigned YEAR_BITS   = 16,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [YIN_BITS-1:0] cfg_wdata_i,
  input  dad_ctl_t            ctl_i,
  output dad_flags_t          flags_o,
  dad_in_if.sink              in_i,
  dad_out_if.source           out_o
);

  localparam int unsigned OW = (OFFSET_BITS < OFFS_BITS) ? OFFSET_BITS : OFFS_BITS;
  localparam int unsigned CW = (YEAR_BITS > YIN_BITS) ? YEAR_BITS : YIN_BITS;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
  localparam logic [M400_BITS:0]   MOD_Y    = 10'd400;
  localparam logic [M400_BITS-1:0] M400_TOP = 9'd399;

  // floor(y / 400) = (y * 83887) >> 25, exact for every 16-bit year
  localparam int unsigned          PROD_BITS   = 33;
  localparam int unsigned          RECIP_SHIFT = 25;
  localparam int unsigned          QUOT_BITS   = PROD_BITS - RECIP_SHIFT;
  localparam logic [PROD_BITS-1:0] RECIP_400   = 33'd83887;

  logic [YIN_BITS-1:0]    min_year_q;
  logic [MONTH_BITS-1:0]  month_q;
  logic [DAY_BITS-1:0]    day_q;
  logic [YIN_BITS-1:0]    yin_q;
  logic [OW-1:0]          offs_q;
  logic                   cnt_q;
  logic [QUOT_BITS-1:0]   quot_q;
  logic [M400_BITS-1:0]   m400_q;
  logic [YEAR_BITS-1:0]   year_q;
  logic [OW:0]            rem_q;
  logic [STATUS_BITS-1:0] status_q;

  logic                   out_valid_q;
  logic [MONTH_BITS-1:0]  out_month_q;
  logic [DAY_BITS-1:0]    out_day_q;
  logic [YIN_BITS-1:0]    out_year_q;
  logic [STATUS_BITS-1:0] out_status_q;

  logic [PROD_BITS-1:0]   prod;
  logic [YIN_BITS-1:0]    m400_full;
  logic [STATUS_BITS-1:0] chk_status;
  logic [DAY_BITS-1:0]    len;
  logic                   more;
  logic                   at_top;
  logic                   out_busy;
  logic                   ok;

  assign in_i.ready = ctl_i.ld_in;

  // Year modulo 400 in two steps: reciprocal multiply, then multiply-subtract
  assign prod      = PROD_BITS'(yin_q) * RECIP_400;
  assign m400_full = yin_q - YIN_BITS'(quot_q) * YIN_BITS'(MOD_Y);

  always_comb begin
    if (month_q < MON_JAN || month_q > MON_DEC) begin
      chk_status = ST_BAD_MONTH;
    end else if (day_q == '0 || day_q > days_in(month_q, is_leap(m400_q))) begin
      chk_status = ST_BAD_DAY;
    end else if (yin_q < min_year_q || CW'(yin_q) > CW'(YEAR_MAX)) begin
      chk_status = ST_BAD_YEAR;
    end else begin
      chk_status = ST_OK;
    end
  end

  assign len      = days_in(month_q, is_leap(m400_q));
  assign more     = rem_q > (OW+1)'(len);
  assign at_top   = (month_q == MON_DEC) && (year_q == YEAR_MAX);
  assign out_busy = out_valid_q && !out_o.ready;
  assign ok       = status_q == ST_OK;

  assign flags_o = '{in_valid: in_i.valid, mod_busy: cnt_q,
                     bad: chk_status != ST_OK, walk_more: more && !at_top,
                     out_busy: out_busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= MIN_YEAR_RST;
    end else if (cfg_we_i) begin
      min_year_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_in) begin
      month_q <= in_i.start_month;
      day_q   <= in_i.start_day;
      yin_q   <= in_i.start_year;
      offs_q  <= OW'(in_i.days_away);
      cnt_q   <= 1'b1;
    end
    if (ctl_i.mod_step) begin
      if (cnt_q) begin
        quot_q <= prod[PROD_BITS-1:RECIP_SHIFT];
      end else begin
        m400_q <= m400_full[M400_BITS-1:0];
      end
      cnt_q <= 1'b0;
    end
    if (ctl_i.check) begin
      status_q <= chk_status;
      year_q   <= YEAR_BITS'(yin_q);
      rem_q    <= (OW+1)'(day_q) + (OW+1)'(offs_q);
    end
    if (ctl_i.walk && more) begin
      if (at_top) begin
        status_q <= ST_OVERFLOW;
      end else begin
        rem_q <= rem_q - (OW+1)'(len);
        if (month_q == MON_DEC) begin
          month_q <= MON_JAN;
          year_q  <= year_q + YEAR_BITS'(1);
          m400_q  <= (m400_q == M400_TOP) ? '0 : m400_q + M400_BITS'(1);
        end else begin
          month_q <= month_q + MONTH_BITS'(1);
        end
      end
    end
    if (ctl_i.emit && !out_busy) begin
      out_month_q  <= ok ? month_q : '0;
      out_day_q    <= ok ? DAY_BITS'(rem_q) : '0;
      out_year_q   <= ok ? YIN_BITS'(year_q) : '0;
      out_status_q <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.new_month = out_month_q;
  assign out_o.new_day   = out_day_q;
  assign out_o.new_year  = out_year_q;
  assign out_o.status    = out_status_q;

endmodule

@@ design/date_add_days.sv @@
// Gregorian date adder: start date plus a day offset, one result per input.
//
// Channels: in_i carries start_month, start_day, start_year and days_away; out_o
// returns new_month, new_day, new_year and status. Both move one transaction on a
// clock edge with valid and ready high. cfg_we_i/cfg_wdata_i write min_year at any
// edge with the write enable high; write it only while the block is idle.
//
// Flow: in_i.ready is high only at the idle step, so one date is in work at a time.
// After a transaction the steps are the start year modulo 400 (reciprocal multiply,
// then multiply-subtract), the check, the month walk, loading the output register
// and the return to idle; a rejected date skips the walk. A 16-bit offset walks up
// to about 2150 months.
//
// Reset: the sequencer returns to idle, the output register empties, min_year goes
// to 1583. There is no clearing pass.
// Stall: a result holds in the output register while out ready is low; the next
// date is accepted meanwhile, and its result waits at the emit step until the
// register frees.
module date_add_days
  import dad_pkg::*;
#(
  parameter int unsigned YEAR_BITS   = 16,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [YIN_BITS-1:0] cfg_wdata_i,
  dad_in_if.sink              in_i,
  dad_out_if.source           out_o
);

  dad_ctl_t   ctl;
  dad_flags_t flags;

  // Control store, step counter and jump logic
  dad_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  // Date registers, year modulo 400, month walker, date check and output register
  dad_datapath #(
    .YEAR_BITS   (YEAR_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (ctl),
    .flags_o     (flags),
    .in_i        (in_i),
    .out_o       (out_o)
  );

endmodule

@@ design/dad_checker.sv @@
module dad_checker
  import dad_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [MONTH_BITS-1:0]  new_month_i,
  input logic [DAY_BITS-1:0]    new_day_i,
  input logic [YIN_BITS-1:0]    new_year_i,
  input logic [STATUS_BITS-1:0] status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(new_month_i) &&
    $stable(new_day_i) && $stable(new_year_i) && $stable(status_i))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |->
    new_month_i == '0 && new_day_i == '0 && new_year_i == '0)
    else $error("error result carries a date");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_OK |->
    new_month_i >= MON_JAN && new_month_i <= MON_DEC && new_day_i != '0)
    else $error("ok result out of calendar range");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_OVERFLOW)
    else $error("undefined status code");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a date is in work");

endmodule

bind date_add_days dad_checker u_dad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .new_month_i (out_o.new_month),
  .new_day_i   (out_o.new_day),
  .new_year_i  (out_o.new_year),
  .status_i    (out_o.status)
);

@@ tb/sv/date_add_days_checker.sv @@
`timescale 1ns / 1ps

module date_add_days_checker
  import dad_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [YIN_BITS-1:0] cfg_wdata_i,
  dad_in_if                   in_mon,
  dad_out_if                  out_mon,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned YEAR_MAX = (1 << YIN_BITS) - 1;

  typedef struct packed {
    logic [MONTH_BITS-1:0]  month;
    logic [DAY_BITS-1:0]    day;
    logic [YIN_BITS-1:0]    year;
    logic [STATUS_BITS-1:0] status;
  } date_result_t;

  date_result_t   dates_due[$];
  logic [YIN_BITS-1:0] floor_year;
  int unsigned    fails;

  function automatic bit year_is_leap(input int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
    case (mon)
      2:            return year_is_leap(yr) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // Validate the start date, then walk it forward one month at a time
  function automatic date_result_t advance_date(input logic [MONTH_BITS-1:0] m,
                                                input logic [DAY_BITS-1:0]   d,
                                                input logic [YIN_BITS-1:0]   y,
                                                input logic [OFFS_BITS-1:0]  offs,
                                                input logic [YIN_BITS-1:0]   low_year);
    date_result_t           r;
    int unsigned            mon;
    int unsigned            yr;
    int unsigned            rem;
    logic [STATUS_BITS-1:0] st;
    mon = 32'(m);
    yr  = 32'(y);
    st  = ST_OK;
    if (mon < 1 || mon > 12) begin
      st = ST_BAD_MONTH;
    end else if (d == 0 || d > month_length(mon, yr)) begin
      st = ST_BAD_DAY;
    end else if (yr < low_year || yr > YEAR_MAX) begin
      st = ST_BAD_YEAR;
    end
    rem = 32'(d);
    if (st == ST_OK) begin
      rem = 32'(d) + 32'(offs);
      while (rem > month_length(mon, yr)) begin
        rem = rem - month_length(mon, yr);
        mon = (mon % 12) + 1;
        if (mon == 1) begin
          if (yr >= YEAR_MAX) begin
            st = ST_OVERFLOW;
            break;
          end
          yr++;
        end
      end
    end
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.month = mon[MONTH_BITS-1:0];
      r.day   = rem[DAY_BITS-1:0];
      r.year  = yr[YIN_BITS-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    date_result_t want;
    date_result_t got;
    if (!rst_ni) begin
      floor_year = MIN_YEAR_RST;
      dates_due.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // predict with the register value in force at this edge, then apply writes
      if (in_mon.valid && in_mon.ready) begin
        dates_due.push_back(advance_date(in_mon.start_month, in_mon.start_day,
                                         in_mon.start_year, in_mon.days_away, floor_year));
      end
      if (cfg_we_i) begin
        floor_year = cfg_wdata_i;
      end
      if (out_mon.valid && out_mon.ready) begin
        got.month  = out_mon.new_month;
        got.day    = out_mon.new_day;
        got.year   = out_mon.new_year;
        got.status = out_mon.status;
        if (dates_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: unexpected result month=%0d day=%0d year=%0d status=%0d",
                     $realtime, got.month, got.day, got.year, got.status);
          end
        end else begin
          want = dates_due.pop_front();
          if (got.month !== want.month || got.day !== want.day ||
              got.year !== want.year || got.status !== want.status) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch exp month=%0d day=%0d year=%0d status=%0d",
                       $realtime, want.month, want.day, want.year, want.status);
              $display("%0t:          got month=%0d day=%0d year=%0d status=%0d",
                       $realtime, got.month, got.day, got.year, got.status);
            end
          end
        end
      end
      pending_o    <= dates_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ tb/sv/date_add_days_tb.sv @@
`timescale 1ns / 1ps

module date_add_days_tb;
  import dad_pkg::*;

  // Longest walk is about 2150 months; allow several times that
  // plus the long receiver hold before declaring a hang.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned DRAIN_WAIT     = 30;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [YIN_BITS-1:0] cfg_wdata;
  logic                hold_req;

  int unsigned   fail_count;
  int unsigned   pending;
  int unsigned   floor_now;
  int unsigned   send_burst;

  dad_in_if  in_ch ();
  dad_out_if out_ch ();

  date_add_days DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  date_add_days_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Idle the sender after a transaction; inside a burst keep valid up
  task automatic rest_sender();
    int unsigned gap;
    if (send_burst > 0) begin
      send_burst--;
    end else begin
      gap = pick_gap();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0) begin
        send_burst = $urandom_range(8, 20);
      end
    end
  endtask

  // Offer one date and hold it until the block takes it
  task automatic send_date(input logic [MONTH_BITS-1:0] m, input logic [DAY_BITS-1:0] d,
                           input logic [YIN_BITS-1:0] y, input logic [OFFS_BITS-1:0] o);
    in_ch.valid       <= 1'b1;
    in_ch.start_month <= m;
    in_ch.start_day   <= d;
    in_ch.start_year  <= y;
    in_ch.days_away   <= o;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rest_sender();
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write min_year while the block is idle; mirror it for the year generator
  task automatic set_min_year(input logic [YIN_BITS-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    floor_now = 32'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed dates with random content; the rest is noise
  task automatic run_random(input int unsigned count);
    logic [MONTH_BITS-1:0] m;
    logic [DAY_BITS-1:0]   d;
    logic [YIN_BITS-1:0]   y;
    logic [OFFS_BITS-1:0]  o;
    int unsigned           r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        m = MONTH_BITS'($urandom_range(0, 15));
        d = DAY_BITS'($urandom_range(0, 31));
      end else begin
        m = MONTH_BITS'($urandom_range(1, 12));
        d = ($urandom_range(0, 4) == 0) ? DAY_BITS'($urandom_range(1, 31)) :
                                          DAY_BITS'($urandom_range(1, 28));
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        y = YIN_BITS'($urandom_range(floor_now, 65535));
      end else if (r < 85) begin
        y = YIN_BITS'($urandom_range((floor_now > 65500) ? floor_now : 65500, 65535));
      end else begin
        y = YIN_BITS'($urandom());
      end
      // keep most offsets short: the walk steps one month at a time
      r = $urandom_range(0, 99);
      if (r < 60) begin
        o = OFFS_BITS'($urandom_range(0, 400));
      end else if (r < 85) begin
        o = OFFS_BITS'($urandom_range(0, 4000));
      end else begin
        o = OFFS_BITS'($urandom());
      end
      send_date(m, d, y, o);
    end
  endtask

  // Receiver: random ready with bursts, plus one long hold-off once requested
  initial begin : receiver
    int unsigned gap;
    int unsigned burst;
    bit          hold_done;
    out_ch.ready = 1'b0;
    burst        = 0;
    hold_done    = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        // hold off long enough for the block to fill and stall its input
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (burst > 0) begin
        burst--;
        out_ch.ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end
        if ($urandom_range(0, 49) == 0) begin
          burst = $urandom_range(10, 40);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid       = 1'b0;
    in_ch.start_month = '0;
    in_ch.start_day   = '0;
    in_ch.start_year  = '0;
    in_ch.days_away   = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    hold_req          = 1'b0;
    rst_n             = 1'b0;
    send_burst        = 0;
    floor_now         = 32'(MIN_YEAR_RST);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, min_year at its reset value
    send_date(4'd0,  5'd0,  16'd0,     16'd0);      // all zeros: bad month
    send_date(4'd15, 5'd31, 16'd65535, 16'hFFFF);   // all ones: bad month wins
    send_date(4'd13, 5'd15, 16'd2000,  16'd10);     // first month past December
    send_date(4'd1,  5'd0,  16'd2000,  16'd5);      // day zero
    send_date(4'd4,  5'd31, 16'd2000,  16'd1);      // day past a 30-day month
    send_date(4'd2,  5'd30, 16'd0,     16'd0);      // bad day reported before bad year
    send_date(4'd2,  5'd29, 16'd1900,  16'd0);      // leap day in a plain century
    send_date(4'd2,  5'd29, 16'd2023,  16'd0);      // leap day in a common year
    send_date(4'd2,  5'd29, 16'd2000,  16'd0);      // leap day in a 400-year century
    send_date(4'd2,  5'd29, 16'd2024,  16'd1);      // leap day rolls into March
    send_date(4'd1,  5'd31, 16'd1582,  16'd0);      // one year below the minimum
    send_date(4'd1,  5'd1,  16'd1583,  16'd0);      // exactly the minimum
    send_date(4'd1,  5'd1,  16'd1583,  16'hFFFF);   // longest offset
    send_date(4'd2,  5'd28, 16'd2100,  16'd1);      // no leap day in 2100
    send_date(4'd2,  5'd28, 16'd2400,  16'd1);      // leap day in 2400
    send_date(4'd12, 5'd31, 16'd65535, 16'd0);      // last representable date
    send_date(4'd12, 5'd31, 16'd65535, 16'd1);      // one day past: year overflow
    send_date(4'd1,  5'd1,  16'd65535, 16'd364);    // walk to the last day of the top year
    send_date(4'd1,  5'd1,  16'd65535, 16'd365);    // and one more: overflow
    send_date(4'd12, 5'd31, 16'd65400, 16'hFFFF);   // long walk that overflows
    send_date(4'd1,  5'd31, 16'd2001,  16'd28);     // land on the end of February
    send_date(4'd11, 5'd30, 16'd1999,  16'd32);     // cross into a new year

    // Random phases over several register settings
    set_min_year(16'd0);
    run_random(70);
    set_min_year(16'hFFFF);
    run_random(25);
    set_min_year(YIN_BITS'($urandom_range(1, 4000)));
    run_random(70);
    set_min_year(MIN_YEAR_RST);
    hold_req <= 1'b1;
    run_random(85);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/dad_pkg.sv
design/dad_in_if.sv
design/dad_out_if.sv
design/dad_useq.sv
design/dad_datapath.sv
design/date_add_days.sv
design/dad_checker.sv
tb/sv/date_add_days_checker.sv
tb/sv/date_add_days_tb.sv
